@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the flattener RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define QBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qbf check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define QBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qbf check failed");

`endif

@@ rtl/core/qbf_pkg.sv @@
// Shared types and fixed constants of the quadratic Bezier flattener.
// No dependencies; used by qbf_eval and the top level.
package qbf_pkg;

    localparam int LEVEL_BITS = 3;   // subdivision level field of a stack entry
    localparam int TOL_BITS   = 16;  // tolerance register width

    // Decision of the evaluation unit for the current node.
    typedef struct packed {
        logic done;    // stage 2 just finished for a new node
        logic emit;    // emit chord (tolerance met or depth limit)
        logic capped;  // emitted because of the depth limit
    } qbf_verdict_t;

endpackage

@@ rtl/core/qbf_stack.sv @@
// Node stack storage: one synchronous RAM, one write and one read port.
// Read data is registered. No package dependency.
module qbf_stack #(
    parameter int ENTRY_W = 123,
    parameter int DEPTH   = 6,
    parameter int ADDR_W  = 3
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/qbf_eval.sv @@
// Two-stage midpoint / flatness unit for one Bezier node.
// Depends on qbf_pkg (verdict struct, field widths).
module qbf_eval #(
    parameter int COORD_BITS = 20,
    parameter int MAX_DEPTH  = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                go,
    input  logic signed [COORD_BITS-1:0]        p0_x,
    input  logic signed [COORD_BITS-1:0]        p0_y,
    input  logic signed [COORD_BITS-1:0]        p1_x,
    input  logic signed [COORD_BITS-1:0]        p1_y,
    input  logic signed [COORD_BITS-1:0]        p2_x,
    input  logic signed [COORD_BITS-1:0]        p2_y,
    input  logic [qbf_pkg::LEVEL_BITS-1:0]      lvl,
    input  logic [qbf_pkg::TOL_BITS-1:0]        tolerance,
    output qbf_pkg::qbf_verdict_t               verdict,
    output logic signed [COORD_BITS-1:0]        q_x,
    output logic signed [COORD_BITS-1:0]        q_y,
    output logic signed [COORD_BITS-1:0]        hl_x,
    output logic signed [COORD_BITS-1:0]        hl_y,
    output logic signed [COORD_BITS-1:0]        hr_x,
    output logic signed [COORD_BITS-1:0]        hr_y
);
    import qbf_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int DIST_W = COORD_BITS + 2;

    // (a + b) / 2 truncated toward zero: bump negative sums by one before the shift.
    function automatic logic signed [CW-1:0] half_sum(input logic signed [CW-1:0] a,
                                                      input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        s = s + {{CW{1'b0}}, s[CW]};
        return s[CW:1];
    endfunction

    function automatic logic [CW:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        return d[CW] ? (~d + 1'b1) : d;
    endfunction

    // stage 1
    logic signed [CW-1:0] mid_x_reg, mid_y_reg;
    logic signed [CW-1:0] hl_x_reg, hl_y_reg, hr_x_reg, hr_y_reg;
    logic                 v1_reg;
    // stage 2
    logic signed [CW-1:0] q_x_reg, q_y_reg;
    logic [CW:0]          ax_reg, ay_reg;
    logic                 v2_reg;

    logic signed [CW-1:0] q_x_next, q_y_next;
    logic [DIST_W-1:0]    err_sum;
    logic                 below, at_limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= go;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            mid_x_reg <= half_sum(p0_x, p2_x);
            mid_y_reg <= half_sum(p0_y, p2_y);
            hl_x_reg  <= half_sum(p0_x, p1_x);
            hl_y_reg  <= half_sum(p0_y, p1_y);
            hr_x_reg  <= half_sum(p1_x, p2_x);
            hr_y_reg  <= half_sum(p1_y, p2_y);
        end
        if (v1_reg) begin
            q_x_reg <= q_x_next;
            q_y_reg <= q_y_next;
            ax_reg  <= abs_diff(mid_x_reg, q_x_next);
            ay_reg  <= abs_diff(mid_y_reg, q_y_next);
        end
    end

    assign q_x_next = half_sum(mid_x_reg, p1_x);
    assign q_y_next = half_sum(mid_y_reg, p1_y);

    assign err_sum  = {1'b0, ax_reg} + {1'b0, ay_reg};
    assign below    = err_sum < DIST_W'(tolerance);
    assign at_limit = lvl >= LEVEL_BITS'(MAX_DEPTH);

    assign verdict.done   = v2_reg;
    assign verdict.emit   = below || at_limit;
    assign verdict.capped = !below;

    assign q_x  = q_x_reg;
    assign q_y  = q_y_reg;
    assign hl_x = hl_x_reg;
    assign hl_y = hl_y_reg;
    assign hr_x = hr_x_reg;
    assign hr_y = hr_y_reg;

endmodule

@@ rtl/core/quad_bezier_flattener_top.sv @@
// Top level of the quadratic Bezier flattener: control sequencer, output register.
// Depends on qbf_pkg, qbf_eval, qbf_stack and assert_macros.svh.
`include "assert_macros.svh"

// One input item is a quadratic Bezier curve (start, control, end; signed twips).
// The curve is cut into line segments by midpoint subdivision: a node whose chord
// midpoint and curve midpoint lie less than `tolerance` apart (Manhattan) is sent
// out as a segment, otherwise it splits and the left half goes first. Nodes at
// level MAX_DEPTH are always sent out, with tuser (depth_capped) set if the node
// is not within tolerance; tlast marks the final segment of a curve. A curve
// yields 1 to 2^MAX_DEPTH segments. Each node visit passes through both stages of
// the evaluation unit, and each return to a stored right half adds a stack RAM
// read in ST_POP and ST_LOAD (issue plus registered data). The next curve is
// taken only after the last segment of the current one has been loaded into the
// output register, and the result side can hold that off.
// Segments wait in a one-deep output register; the unit stalls only when that
// register is still full. Halving truncates toward zero. The stack needs no
// clearing after reset: every entry is written before it is read.
module quad_bezier_flattener_top #(
    parameter int COORD_BITS = 20,
    parameter int MAX_DEPTH  = 6,
    parameter int S_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8,
    parameter int M_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tolerance register write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qbf_pkg::TOL_BITS-1:0]    cfg_data,
    // curve input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // lowest bit up: start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, zero pad
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // segment output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // lowest bit up: seg_x0, seg_y0, seg_x1, seg_y1, zero pad
    output logic [M_TDATA_W-1:0]            m_tdata,
    output logic                            m_tlast,   // last_seg
    output logic                            m_tuser    // depth_capped
);
    import qbf_pkg::*;

    localparam int CW      = COORD_BITS;
    localparam int SP_W    = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ENTRY_W = 6 * CW + LEVEL_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STALL,
        ST_POP,
        ST_LOAD
    } state_t;

    state_t state_reg;

    logic [TOL_BITS-1:0]   tolerance_reg;
    logic [SP_W-1:0]       sp_reg;
    logic                  go_reg;
    logic                  go_next;

    // current node
    logic signed [CW-1:0]  p0_x_reg, p0_y_reg, p1_x_reg, p1_y_reg, p2_x_reg, p2_y_reg;
    logic [LEVEL_BITS-1:0] lvl_reg;

    // output register
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic signed [CW-1:0]  o_x0_reg, o_y0_reg, o_x1_reg, o_y1_reg;
    logic                  o_last_reg, o_capped_reg;

    qbf_verdict_t          verdict;
    logic signed [CW-1:0]  q_x, q_y, hl_x, hl_y, hr_x, hr_y;

    logic                  decide, out_free, emit_go, split_go, s_accept;
    logic [SP_W-1:0]       sp_dec;
    logic                  st_we, st_re;
    logic [ADDR_W-1:0]     st_waddr, st_raddr;
    logic [ENTRY_W-1:0]    st_wdata, st_rdata;
    logic [LEVEL_BITS-1:0] lvl_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;

    assign decide   = (state_reg == ST_EVAL && verdict.done) || (state_reg == ST_STALL);
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_go  = decide && verdict.emit && out_free;
    assign split_go = decide && !verdict.emit;

    // start the evaluation unit on a new curve, a left half or a popped node
    assign go_next       = s_accept || split_go || (state_reg == ST_LOAD);
    // load on emit, hold until the result side takes the item
    assign m_tvalid_next = emit_go || (m_tvalid_reg && !m_tready);

    assign lvl_inc = lvl_reg + LEVEL_BITS'(1);
    assign sp_dec  = sp_reg - SP_W'(1);

    // push the right half; the left half stays in the node registers
    assign st_we    = split_go;
    assign st_waddr = sp_reg[ADDR_W-1:0];
    assign st_wdata = {lvl_inc, p2_y_reg, p2_x_reg, hr_y, hr_x, q_y, q_x};
    assign st_re    = (state_reg == ST_POP);
    assign st_raddr = sp_dec[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= TOL_BITS'(1);
        end else if (cfg_valid && cfg_ready) begin
            tolerance_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sp_reg       <= '0;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            go_reg       <= go_next;
            m_tvalid_reg <= m_tvalid_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        p0_x_reg  <= s_tdata[0*CW +: CW];
                        p0_y_reg  <= s_tdata[1*CW +: CW];
                        p1_x_reg  <= s_tdata[2*CW +: CW];
                        p1_y_reg  <= s_tdata[3*CW +: CW];
                        p2_x_reg  <= s_tdata[4*CW +: CW];
                        p2_y_reg  <= s_tdata[5*CW +: CW];
                        lvl_reg   <= '0;
                        sp_reg    <= '0;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL, ST_STALL: begin
                    if (emit_go) begin
                        o_x0_reg     <= p0_x_reg;
                        o_y0_reg     <= p0_y_reg;
                        o_x1_reg     <= p2_x_reg;
                        o_y1_reg     <= p2_y_reg;
                        o_last_reg   <= (sp_reg == '0);
                        o_capped_reg <= verdict.capped;
                        state_reg    <= (sp_reg == '0) ? ST_IDLE : ST_POP;
                    end else if (split_go) begin
                        // continue with the left half
                        p1_x_reg  <= hl_x;
                        p1_y_reg  <= hl_y;
                        p2_x_reg  <= q_x;
                        p2_y_reg  <= q_y;
                        lvl_reg   <= lvl_inc;
                        sp_reg    <= sp_reg + SP_W'(1);
                        state_reg <= ST_EVAL;
                    end else if (decide) begin
                        state_reg <= ST_STALL;   // output register still full
                    end
                end
                ST_POP: begin
                    sp_reg    <= sp_dec;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    p0_x_reg  <= st_rdata[0*CW +: CW];
                    p0_y_reg  <= st_rdata[1*CW +: CW];
                    p1_x_reg  <= st_rdata[2*CW +: CW];
                    p1_y_reg  <= st_rdata[3*CW +: CW];
                    p2_x_reg  <= st_rdata[4*CW +: CW];
                    p2_y_reg  <= st_rdata[5*CW +: CW];
                    lvl_reg   <= st_rdata[6*CW +: LEVEL_BITS];
                    state_reg <= ST_EVAL;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    qbf_eval #(
        .COORD_BITS (COORD_BITS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go_reg),
        .p0_x      (p0_x_reg),
        .p0_y      (p0_y_reg),
        .p1_x      (p1_x_reg),
        .p1_y      (p1_y_reg),
        .p2_x      (p2_x_reg),
        .p2_y      (p2_y_reg),
        .lvl       (lvl_reg),
        .tolerance (tolerance_reg),
        .verdict   (verdict),
        .q_x       (q_x),
        .q_y       (q_y),
        .hl_x      (hl_x),
        .hl_y      (hl_y),
        .hr_x      (hr_x),
        .hr_y      (hr_y)
    );

    qbf_stack #(
        .ENTRY_W (ENTRY_W),
        .DEPTH   (MAX_DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_stack (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    // zero pad above the four coordinates
    assign m_tdata  = M_TDATA_W'({o_y1_reg, o_x1_reg, o_y0_reg, o_x0_reg});
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_capped_reg;

    // stack is empty whenever a new curve can be taken
    `QBF_ASSERT_NOW(a_idle_stack_empty, aclk, aresetn, s_tready, sp_reg == '0)
    // a push never overruns the stack
    `QBF_ASSERT_NOW(a_push_in_range, aclk, aresetn, st_we, sp_reg < SP_W'(MAX_DEPTH))
    // a pop only happens with something stored
    `QBF_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, st_re, sp_reg != '0)
    // a read is always followed by the load of the node registers
    `QBF_ASSERT_NEXT(a_read_then_load, aclk, aresetn, st_re, state_reg == ST_LOAD)

endmodule

@@ verif/quad_bezier_flattener_top_tb.sv @@
// Self-checking testbench for quad_bezier_flattener_top: drives curves and tolerance
// writes, predicts the emitted segments and checks each one in order.
// Depends on qbf_pkg and the flattener RTL only.
`timescale 1ns / 1ps

module quad_bezier_flattener_top_tb;

    localparam int COORD_BITS = 20;
    localparam int MAX_DEPTH  = 6;
    localparam int TOL_BITS   = qbf_pkg::TOL_BITS;
    localparam int S_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int STACK_SLOTS = MAX_DEPTH + 1;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 20'sh7FFFF;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = 20'sh80000;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_CURVES = 35;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 40;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t sx, sy, cx, cy, ex, ey;
    } curve_t;

    typedef struct {
        coord_t x0, y0, x1, y1;
        logic   last_seg;
        logic   capped;
    } seg_t;

    typedef struct {
        longint x;
        longint y;
    } point_t;

    // Predicts the segments of each accepted curve and checks outgoing segments.
    class segment_scoreboard;
        logic [qbf_pkg::TOL_BITS-1:0] tolerance;
        seg_t expected_segments[$];
        int unsigned errors;

        function new();
            tolerance = TOL_BITS'(1);
            errors = 0;
        endfunction

        function point_t midpoint(point_t a, point_t b);
            midpoint.x = (a.x + b.x) / 2;   // longint division truncates toward zero
            midpoint.y = (a.y + b.y) / 2;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Explicit-stack de Casteljau subdivision, left half on top.
        function void accept_curve(curve_t c);
            point_t st[STACK_SLOTS], ct[STACK_SLOTS], en[STACK_SLOTS];
            int unsigned lv[STACK_SLOTS];
            int unsigned depth;
            point_t p0, p1, p2, m, q;
            int unsigned l;
            longint err_sum;
            logic flat;
            seg_t s;

            st[0].x = longint'(c.sx); st[0].y = longint'(c.sy);
            ct[0].x = longint'(c.cx); ct[0].y = longint'(c.cy);
            en[0].x = longint'(c.ex); en[0].y = longint'(c.ey);
            lv[0] = 0;
            depth = 1;
            while (depth > 0) begin
                depth--;
                p0 = st[depth];
                p1 = ct[depth];
                p2 = en[depth];
                l = lv[depth];
                m = midpoint(p0, p2);
                q = midpoint(m, p1);
                err_sum = mag(m.x - q.x) + mag(m.y - q.y);
                flat = (err_sum < longint'(tolerance));
                if (flat || l >= MAX_DEPTH) begin
                    s.x0 = p0.x[COORD_BITS-1:0];
                    s.y0 = p0.y[COORD_BITS-1:0];
                    s.x1 = p2.x[COORD_BITS-1:0];
                    s.y1 = p2.y[COORD_BITS-1:0];
                    s.last_seg = (depth == 0);
                    s.capped = !flat;
                    expected_segments = {expected_segments, s};
                end else begin
                    // right half first so the left half is popped next
                    st[depth] = q; ct[depth] = midpoint(p1, p2); en[depth] = p2;
                    lv[depth] = l + 1;
                    st[depth+1] = p0; ct[depth+1] = midpoint(p0, p1); en[depth+1] = q;
                    lv[depth+1] = l + 1;
                    depth += 2;
                end
            end
        endfunction

        function void report_field(string name, longint want, longint got);
            errors++;
            $display("%0t ns segment %s mismatch: expected %0d actual %0d",
                     $time, name, want, got);
        endfunction

        function void check_segment(seg_t got);
            seg_t want;
            if (expected_segments.size() == 0) begin
                errors++;
                $display("%0t ns unexpected segment: expected none actual (%0d,%0d)-(%0d,%0d)",
                         $time, got.x0, got.y0, got.x1, got.y1);
                return;
            end
            want = expected_segments.pop_front();
            if (got.x0 !== want.x0) report_field("x0", want.x0, got.x0);
            if (got.y0 !== want.y0) report_field("y0", want.y0, got.y0);
            if (got.x1 !== want.x1) report_field("x1", want.x1, got.x1);
            if (got.y1 !== want.y1) report_field("y1", want.y1, got.y1);
            if (got.last_seg !== want.last_seg)
                report_field("last_seg", want.last_seg, got.last_seg);
            if (got.capped !== want.capped)
                report_field("depth_capped", want.capped, got.capped);
        endfunction

        function int unsigned outstanding();
            return expected_segments.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [qbf_pkg::TOL_BITS-1:0]  cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [S_TDATA_W-1:0]          s_tdata;   // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
    logic                          m_tvalid;
    logic                          m_tready;
    logic [M_TDATA_W-1:0]          m_tdata;   // seg_x0, seg_y0, seg_x1, seg_y1
    logic                          m_tlast;   // last_seg
    logic                          m_tuser;   // depth_capped

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        rx_hold;
    logic        long_hold_go;

    segment_scoreboard sb;

    quad_bezier_flattener_top #(
        .COORD_BITS (COORD_BITS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("FAIL quad_bezier_flattener_top");
        $finish;
    end

    // ---------------- stimulus helpers ----------------

    function automatic coord_t rand_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_BITS-1:0];
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic coord_t pick_extreme();
        case ($urandom_range(0, 4))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return '1;
            default: return rand_coord();
        endcase
    endfunction

    function automatic curve_t make_curve(longint sx, longint sy, longint cx, longint cy,
                                          longint ex, longint ey);
        curve_t c;
        c.sx = clamp_coord(sx); c.sy = clamp_coord(sy);
        c.cx = clamp_coord(cx); c.cy = clamp_coord(cy);
        c.ex = clamp_coord(ex); c.ey = clamp_coord(ey);
        return c;
    endfunction

    // Mix of full-range, local, nearly flat and extreme-valued curves.
    function automatic curve_t random_curve();
        curve_t c;
        longint bx, by, spread;
        case ($urandom_range(0, 3))
            0: begin
                c.sx = rand_coord(); c.sy = rand_coord();
                c.cx = rand_coord(); c.cy = rand_coord();
                c.ex = rand_coord(); c.ey = rand_coord();
            end
            1: begin
                bx = longint'(rand_coord());
                by = longint'(rand_coord());
                spread = longint'(1) << $urandom_range(0, 19);
                c = make_curve(bx, by,
                    bx + longint'($urandom_range(0, 2 * spread)) - spread,
                    by + longint'($urandom_range(0, 2 * spread)) - spread,
                    bx + longint'($urandom_range(0, 2 * spread)) - spread,
                    by + longint'($urandom_range(0, 2 * spread)) - spread);
            end
            2: begin
                c.sx = rand_coord(); c.sy = rand_coord();
                c.ex = rand_coord(); c.ey = rand_coord();
                bx = (longint'(c.sx) + longint'(c.ex)) / 2;
                by = (longint'(c.sy) + longint'(c.ey)) / 2;
                c.cx = clamp_coord(bx + longint'($urandom_range(0, 16)) - 8);
                c.cy = clamp_coord(by + longint'($urandom_range(0, 16)) - 8);
            end
            default: begin
                c.sx = pick_extreme(); c.sy = pick_extreme();
                c.cx = pick_extreme(); c.cy = pick_extreme();
                c.ex = pick_extreme(); c.ey = pick_extreme();
            end
        endcase
        return c;
    endfunction

    function automatic logic [qbf_pkg::TOL_BITS-1:0] random_tolerance();
        case ($urandom_range(0, 2))
            0: return TOL_BITS'($urandom_range(1, 16));
            1: return TOL_BITS'($urandom_range(17, 4096));
            default: return TOL_BITS'($urandom_range(1, 65535));
        endcase
    endfunction

    // Called at a rising edge; returns at the rising edge that took the item.
    task automatic send_curve(input curve_t c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({c.ey, c.ex, c.cy, c.cx, c.sy, c.sx});
        do @(negedge aclk); while (!s_tready);
        sb.accept_curve(c);
        @(posedge aclk);
    endtask

    // Sender stops offering and waits for every expected segment.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Only called with the block idle and the sender stopped.
    task automatic write_tolerance(input logic [qbf_pkg::TOL_BITS-1:0] tol);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        do @(negedge aclk); while (!cfg_ready);
        sb.tolerance = tol;
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- result side ----------------

    initial begin
        rx_hold = 1'b0;
        wait (long_hold_go === 1'b1);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        seg_t got;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
            @(negedge aclk);
            if (m_tvalid && m_tready) begin
                got.x0 = m_tdata[COORD_BITS-1:0];
                got.y0 = m_tdata[2*COORD_BITS-1:COORD_BITS];
                got.x1 = m_tdata[3*COORD_BITS-1:2*COORD_BITS];
                got.y1 = m_tdata[4*COORD_BITS-1:3*COORD_BITS];
                got.last_seg = m_tlast;
                got.capped = m_tuser;
                sb.check_segment(got);
            end
            @(posedge aclk);
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        sb = new();
        send_idle_pct = 19;
        recv_idle_pct = 46;
        long_hold_go = 1'b0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed curves at the reset tolerance of 1.
        send_curve(make_curve(0, 0, 0, 0, 0, 0));                       // degenerate point
        send_curve(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX));
        send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN));
        send_curve(make_curve(-1000, 0, 0, 0, 1000, 0));                // straight line
        send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                              COORD_MAX, COORD_MIN));                   // hits depth limit
        send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MIN));
        send_curve(make_curve(-3, -5, -7, 2, 4, -1));                   // odd sums, truncation
        wait_drained();

        // Zero tolerance: every node splits down to the depth limit.
        write_tolerance('0);
        send_curve(make_curve(0, 0, 0, 0, 0, 0));
        send_curve(make_curve(-17, 33, 250, -9, 41, 12));
        wait_drained();

        // Largest tolerance.
        write_tolerance('1);
        send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                              COORD_MAX, COORD_MIN));
        send_curve(make_curve(1000, 2000, 300000, -400000, -2000, 5));
        send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN));

        // Random phases; the sender drains before each tolerance change.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if (ph < 4) begin
                send_idle_pct = 19;
                recv_idle_pct = 46;
            end else if (ph < 8) begin
                send_idle_pct = 46;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: write_tolerance(TOL_BITS'(1));
                1: write_tolerance(16'hFFFF);
                6: write_tolerance('0);
                default: write_tolerance(random_tolerance());
            endcase
            // long result-side stall while curves keep coming
            if (ph == 2) long_hold_go = 1'b1;
            for (int k = 0; k < PHASE_CURVES; k++)
                send_curve(random_curve());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS quad_bezier_flattener_top");
        end else begin
            $display("FAIL quad_bezier_flattener_top");
        end
        $finish;
    end

endmodule
